@@ rtl/apg_pkg.sv @@
`default_nettype none

package apg_pkg;

  // Trace shape
  localparam int ARC_POINTS  = 50;
  localparam int LEAD_POINTS = 20;
  localparam int ANGLE_BITS  = 16;

  // Point counter wide enough for any arc or lead length
  localparam int IDX_W = 10;

  // Angle widths
  localparam int SPAN_W = ANGLE_BITS + 1;
  localparam logic [SPAN_W-1:0]     FULL_TURN = SPAN_W'(1) << ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // Offset divide by constant: numerator is at most span * index
  localparam int NUM_W  = SPAN_W + IDX_W;
  localparam int MUL_W  = NUM_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Reciprocals, exact for every numerator below 2^NUM_W
  localparam int ARC_SHIFT  = NUM_W + $clog2(ARC_POINTS);
  localparam int LEAD_SHIFT = NUM_W + $clog2(LEAD_POINTS);
  localparam longint unsigned ARC_RECIP_L =
    ((64'd1 << ARC_SHIFT) + 64'(ARC_POINTS) - 64'd1) / 64'(ARC_POINTS);
  localparam longint unsigned LEAD_RECIP_L =
    ((64'd1 << LEAD_SHIFT) + 64'(LEAD_POINTS) - 64'd1) / 64'(LEAD_POINTS);
  localparam logic [MUL_W-1:0] ARC_RECIP  = MUL_W'(ARC_RECIP_L);
  localparam logic [MUL_W-1:0] LEAD_RECIP = MUL_W'(LEAD_RECIP_L);

  // Trace parts
  localparam logic [1:0] PART_IN  = 2'd0;
  localparam logic [1:0] PART_ARC = 2'd1;
  localparam logic [1:0] PART_OUT = 2'd2;

  // Register map, index = paddr[4:2]
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_START_ANGLE = 3'd3;
  localparam logic [2:0] REG_ARC_SPAN    = 3'd4;
  localparam logic [16:0] ARC_SPAN_RESET = 17'h10000;

  // CORDIC: 32-bit binary angle, Q30 vectors
  localparam int CORDIC_STEPS = 24;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int TRIG_W       = 34;
  localparam int Z_W          = 33;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        radius;
    logic [15:0]        start_angle;
    logic [16:0]        arc_span;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/apg_regs.sv @@
`default_nettype none

module apg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output apg_pkg::cfg_t     cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.radius      <= '0;
      cfg.start_angle <= '0;
      cfg.arc_span    <= apg_pkg::ARC_SPAN_RESET;
    end else if (wr) begin
      case (idx)
        apg_pkg::REG_CENTER_X:    cfg.center_x    <= pwdata[15:0];
        apg_pkg::REG_CENTER_Y:    cfg.center_y    <= pwdata[15:0];
        apg_pkg::REG_RADIUS:      cfg.radius      <= pwdata[14:0];
        apg_pkg::REG_START_ANGLE: cfg.start_angle <= pwdata[15:0];
        apg_pkg::REG_ARC_SPAN:    cfg.arc_span    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (idx)
      apg_pkg::REG_CENTER_X:    prdata = {16'd0, cfg.center_x};
      apg_pkg::REG_CENTER_Y:    prdata = {16'd0, cfg.center_y};
      apg_pkg::REG_RADIUS:      prdata = {17'd0, cfg.radius};
      apg_pkg::REG_START_ANGLE: prdata = {16'd0, cfg.start_angle};
      apg_pkg::REG_ARC_SPAN:    prdata = {15'd0, cfg.arc_span};
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/apg_cordic.sv @@
`default_nettype none

module apg_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [31:0]                           angle,
  output logic                                  done,
  output logic signed [apg_pkg::TRIG_W-1:0]     cos_out,
  output logic signed [apg_pkg::TRIG_W-1:0]     sin_out
);

  logic                                run;
  logic [apg_pkg::ITER_W-1:0]          iter;
  logic signed [apg_pkg::TRIG_W-1:0]   x;
  logic signed [apg_pkg::TRIG_W-1:0]   y;
  logic signed [apg_pkg::Z_W-1:0]      z;
  logic                                flip;
  logic                                flip_in;
  logic signed [apg_pkg::TRIG_W-1:0]   dx;
  logic signed [apg_pkg::TRIG_W-1:0]   dy;
  logic signed [apg_pkg::Z_W-1:0]      da;

  // Second and third quadrants are rotated by a half turn first
  assign flip_in = angle[31] ^ angle[30];

  // Shared micro-rotation
  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign da = signed'({1'b0, apg_pkg::ATAN_TAB[iter]});

  // Iteration counter; iter stays on the last step once finished
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        iter <= '0;
      end else if (run) begin
        if (iter == apg_pkg::ITER_W'(apg_pkg::CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  // Vector and residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= apg_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= signed'({angle[31] ^ flip_in, angle[31] ^ flip_in, angle[30:0]});
    end else if (run) begin
      if (!z[apg_pkg::Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule

`default_nettype wire

@@ rtl/arc_point_generator.sv @@
// Each point runs through these steps in order: the accept, two offset multiply
// steps, the CORDIC load, the CORDIC iterations, the CORDIC done cycle, two radius
// multiplies and the output load. A new request is taken only once the point
// before it has been loaded into the output register.
// A finished point waits in the output register while the next request runs.
// Reset (rst, synchronous, active high) clears the registers to their defaults,
// the trace position to the first lead-in point and the output to empty.
`default_nettype none

module arc_point_generator (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] point_x, [31:16] point_y
  output logic [7:0]  m_tuser,   // [0] beam_on, [2:1] trace_part, [7:3] zero
  output logic        m_tlast,   // last_point
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COORD_PW = apg_pkg::TRIG_W + 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ANG  = 3'd3;
  localparam logic [2:0] S_CORD = 3'd4;
  localparam logic [2:0] S_MX   = 3'd5;
  localparam logic [2:0] S_MY   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  apg_pkg::cfg_t cfg;

  logic [2:0]                          state;
  logic [1:0]                          part_now;
  logic [apg_pkg::IDX_W-1:0]           point_index;
  logic [1:0]                          cur_part;
  logic [apg_pkg::IDX_W-1:0]           cur_k;
  logic                                cur_last;
  logic [apg_pkg::PROD_W-1:0]          mul_p;
  logic [apg_pkg::ANGLE_BITS-1:0]      angle;
  logic signed [COORD_PW-1:0]          coord_p;
  logic [15:0]                         px;

  logic                                accept;
  logic [1:0]                          p0;
  logic [apg_pkg::IDX_W-1:0]           k0;
  logic [apg_pkg::IDX_W:0]             k_inc;
  logic [1:0]                          part_next;
  logic [apg_pkg::IDX_W-1:0]           index_next;
  logic                                last_next;
  logic [apg_pkg::SPAN_W-1:0]          span_eff;
  logic [apg_pkg::ANGLE_BITS-1:0]      start_eff;
  logic                                span_zero;
  logic [apg_pkg::MUL_W-1:0]           mul_a;
  logic [apg_pkg::MUL_W-1:0]           mul_b;
  logic [apg_pkg::ANGLE_BITS-1:0]      base;
  logic [apg_pkg::ANGLE_BITS-1:0]      offset;
  logic                                cordic_start;
  logic                                cordic_done;
  logic signed [apg_pkg::TRIG_W-1:0]   cos_v;
  logic signed [apg_pkg::TRIG_W-1:0]   sin_v;
  logic signed [apg_pkg::TRIG_W-1:0]   trig_sel;
  logic signed [COORD_PW-1:0]          rad_s;
  logic                                out_load;

  apg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apg_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   ({angle, {(32 - apg_pkg::ANGLE_BITS){1'b0}}}),
    .done    (cordic_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  // Round half up, add center, saturate to 16 bits
  function automatic logic [15:0] coord(input logic signed [15:0] ctr,
                                        input logic signed [COORD_PW-1:0] p);
    logic signed [COORD_PW-1:0]   rnd;
    logic signed [COORD_PW-31:0]  t;
    logic signed [COORD_PW-29:0]  v;
    rnd = p + signed'({{(COORD_PW - 30){1'b0}}, 1'b1, 29'd0});
    t   = rnd[COORD_PW-1:30];
    v   = (COORD_PW-28)'(ctr) + (COORD_PW-28)'(t);
    if (v > (COORD_PW-28)'(32767))
      return 16'h7FFF;
    else if (v < -(COORD_PW-28)'(32768))
      return 16'h8000;
    else
      return v[15:0];
  endfunction

  // Effective config
  always_comb begin
    if (32'(cfg.arc_span) > 32'(apg_pkg::FULL_TURN))
      span_eff = apg_pkg::FULL_TURN;
    else
      span_eff = apg_pkg::SPAN_W'(cfg.arc_span);
  end
  assign start_eff = apg_pkg::ANGLE_BITS'(cfg.start_angle);
  assign span_zero = (span_eff == '0);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Trace position for this request and the one after
  always_comb begin
    p0 = s_tdata[0] ? apg_pkg::PART_IN : part_now;
    k0 = s_tdata[0] ? '0 : point_index;
    if (p0 == apg_pkg::PART_ARC && span_zero) begin
      p0 = apg_pkg::PART_OUT;
      k0 = '0;
    end
    k_inc      = {1'b0, k0} + 1'b1;
    part_next  = p0;
    index_next = k_inc[apg_pkg::IDX_W-1:0];
    last_next  = 1'b0;
    case (p0)
      apg_pkg::PART_IN: begin
        if (k_inc >= (apg_pkg::IDX_W+1)'(apg_pkg::LEAD_POINTS)) begin
          part_next  = span_zero ? apg_pkg::PART_OUT : apg_pkg::PART_ARC;
          index_next = '0;
        end
      end
      apg_pkg::PART_ARC: begin
        if (k_inc >= (apg_pkg::IDX_W+1)'(apg_pkg::ARC_POINTS)) begin
          part_next  = apg_pkg::PART_OUT;
          index_next = '0;
        end
      end
      default: begin
        if (k_inc >= (apg_pkg::IDX_W+1)'(apg_pkg::LEAD_POINTS)) begin
          part_next  = apg_pkg::PART_IN;
          index_next = '0;
          last_next  = 1'b1;
        end
      end
    endcase
  end

  // Shared offset multiplier: step * index, then times reciprocal
  always_comb begin
    if (state == S_MUL2) begin
      mul_a = mul_p[apg_pkg::MUL_W-1:0];
      mul_b = (cur_part == apg_pkg::PART_ARC) ? apg_pkg::ARC_RECIP : apg_pkg::LEAD_RECIP;
    end else begin
      mul_a = (cur_part == apg_pkg::PART_ARC) ? apg_pkg::MUL_W'(span_eff)
                                              : apg_pkg::MUL_W'(apg_pkg::QUARTER);
      mul_b = apg_pkg::MUL_W'(cur_k);
    end
  end

  // Point angle from part base and quotient
  always_comb begin
    case (cur_part)
      apg_pkg::PART_IN:  base = start_eff - apg_pkg::QUARTER;
      apg_pkg::PART_ARC: base = start_eff;
      default:           base = start_eff + span_eff[apg_pkg::ANGLE_BITS-1:0];
    endcase
    if (cur_part == apg_pkg::PART_ARC)
      offset = mul_p[apg_pkg::ARC_SHIFT +: apg_pkg::ANGLE_BITS];
    else
      offset = mul_p[apg_pkg::LEAD_SHIFT +: apg_pkg::ANGLE_BITS];
  end

  // CORDIC loads this angle at the edge that leaves S_ANG
  assign angle        = base + offset;
  assign cordic_start = (state == S_ANG);
  assign trig_sel     = (state == S_MX) ? cos_v : sin_v;
  assign rad_s        = COORD_PW'(signed'({1'b0, cfg.radius}));
  assign out_load     = (state == S_OUT) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      part_now    <= apg_pkg::PART_IN;
      point_index <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            part_now    <= part_next;
            point_index <= index_next;
            state       <= S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_ANG;
        S_ANG:  state <= S_CORD;
        S_CORD: if (cordic_done) state <= S_MX;
        S_MX:   state <= S_MY;
        S_MY:   state <= S_OUT;
        S_OUT:  if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_part <= p0;
      cur_k    <= k0;
      cur_last <= last_next;
    end
    if (state == S_MUL1 || state == S_MUL2)
      mul_p <= mul_a * mul_b;
    if (state == S_MX || state == S_MY)
      coord_p <= rad_s * COORD_PW'(trig_sel);
    if (state == S_MY)
      px <= coord(cfg.center_x, coord_p);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {coord(cfg.center_y, coord_p), px};
      m_tuser <= {5'd0, cur_part, cur_part == apg_pkg::PART_ARC};
      m_tlast <= cur_last;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while a point is in progress");

  a_last_in_lead_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser[2:1] == apg_pkg::PART_OUT))
    else $error("last point outside lead-out");

  a_beam_only_on_arc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == apg_pkg::PART_ARC))
    else $error("beam lit outside arc");

  a_lead_index_range: assert property (@(posedge clk) disable iff (rst)
    (part_now == apg_pkg::PART_IN || part_now == apg_pkg::PART_OUT)
      |-> (point_index < apg_pkg::IDX_W'(apg_pkg::LEAD_POINTS)))
    else $error("lead point index out of range");

endmodule

`default_nettype wire
